>>> rtl/ppc_subset_decode_execute_top_assert.svh
// Assertion macros used by the checker of the PowerPC subset execute block
`ifndef PPC_SUBSET_DECODE_EXECUTE_TOP_ASSERT_SVH
`define PPC_SUBSET_DECODE_EXECUTE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define PPCDE_ASSERT_NOW(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("ppcde assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PPCDE_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("ppcde assertion failed");

`endif

>>> rtl/ppcde_pkg.sv
// Shared types and constants for the PowerPC subset execute block
package ppcde_pkg;

	// Field widths
	localparam int unsigned XLEN    = 64;
	localparam int unsigned ILEN    = 32;
	localparam int unsigned CRLEN   = 32;
	localparam int unsigned RIDX_W  = 5;
	localparam int unsigned LEVEL_W = 7;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNSUP   = 2'd1,
		ST_SYSCALL = 2'd2
	} status_t;

	// Primary opcodes
	localparam logic [5:0] OP_ADDI  = 6'd14;
	localparam logic [5:0] OP_ADDIS = 6'd15;
	localparam logic [5:0] OP_SC    = 6'd17;
	localparam logic [5:0] OP_B     = 6'd18;
	localparam logic [5:0] OP_GRP19 = 6'd19;
	localparam logic [5:0] OP_ORI   = 6'd24;
	localparam logic [5:0] OP_ORIS  = 6'd25;
	localparam logic [5:0] OP_XORI  = 6'd26;
	localparam logic [5:0] OP_XORIS = 6'd27;
	localparam logic [5:0] OP_GRP31 = 6'd31;

	// Extended opcodes
	localparam logic [9:0] XO19_ISYNC = 10'd150;
	localparam logic [9:0] XO19_CRXOR = 10'd193;
	localparam logic [9:0] XO31_MFMSR = 10'd83;
	localparam logic [9:0] XO31_MTMSR = 10'd146;
	localparam logic [9:0] XO31_MFSPR = 10'd339;
	localparam logic [9:0] XO31_OR    = 10'd444;

	// Link register SPR number, low half (the high half must be zero)
	localparam logic [4:0] SPR_LR_LO = 5'd8;

endpackage

>>> rtl/ppc_subset_decode_execute_top.sv
// Top level: PowerPC integer subset execute stage with register file memory
//
// Executes one 32-bit PowerPC instruction per item against 32 64-bit general
// registers, CR, LR, MSR and PC. One item is accepted per cycle unless the
// output register stalls. The general registers sit in a synchronous memory
// with two read ports: the operands are read at the edge that accepts the
// item, and the instruction executes from the execute stage, writing back to
// the memory and an output register once that register is free or drained.
// The most recent write-back is forwarded to the next instruction, so dependent
// instructions issue back to back with no bubble. Unwritten entries read zero
// through per-entry valid bits; no clearing pass runs after reset. The output
// register takes a new result in the same cycle that the previous one is taken.
module ppc_subset_decode_execute_top #(
	parameter int unsigned REG_COUNT = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ppcde_pkg::ILEN-1:0]          instr_word,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic [ppcde_pkg::XLEN-1:0]          next_pc,
	output logic                                dest_valid,
	output logic [ppcde_pkg::RIDX_W-1:0]        dest_index,
	output logic [ppcde_pkg::XLEN-1:0]          dest_value,
	output logic [ppcde_pkg::LEVEL_W-1:0]       syscall_level,
	output logic [ppcde_pkg::CRLEN-1:0]         cr_value,
	output logic [ppcde_pkg::XLEN-1:0]          lr_value
);

	localparam int unsigned IDX_W = $clog2(REG_COUNT);

	// Register file memory and per-entry written flags
	logic [ppcde_pkg::XLEN-1:0] gpr_mem [REG_COUNT];
	logic [REG_COUNT-1:0]       gpr_valid_q;

	// Architectural state
	logic [ppcde_pkg::XLEN-1:0]  pc_q;
	logic [ppcde_pkg::XLEN-1:0]  lr_q;
	logic [ppcde_pkg::CRLEN-1:0] cr_q;
	logic [ppcde_pkg::XLEN-1:0]  msr_q;

	// Execute stage
	logic                        valid_s1;
	logic [ppcde_pkg::ILEN-1:0]  instr_s1;
	logic [ppcde_pkg::XLEN-1:0]  rda_s1;
	logic [ppcde_pkg::XLEN-1:0]  rdb_s1;

	// Last write-back, forwarded over the stale memory read
	logic                        fwd_en_q;
	logic [IDX_W-1:0]            fwd_idx_q;
	logic [ppcde_pkg::XLEN-1:0]  fwd_val_q;

	// Output register
	logic                                 out_valid_q;
	ppcde_pkg::status_t                   status_q;
	logic [ppcde_pkg::XLEN-1:0]           next_pc_q;
	logic                                 dest_valid_q;
	logic [ppcde_pkg::RIDX_W-1:0]         dest_index_q;
	logic [ppcde_pkg::XLEN-1:0]           dest_value_q;
	logic [ppcde_pkg::LEVEL_W-1:0]        level_q;
	logic [ppcde_pkg::CRLEN-1:0]          cr_out_q;
	logic [ppcde_pkg::XLEN-1:0]           lr_out_q;

	logic in_fire;
	logic ex_fire;

	// Handshake: execute when the output register is free or being drained
	assign ex_fire  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || ex_fire;
	assign in_fire  = in_valid && in_ready;

	// Read addresses from the incoming word
	logic [5:0]       in_op;
	logic [IDX_W-1:0] rd_addr_a;
	logic [IDX_W-1:0] rd_addr_b;

	always_comb begin
		in_op     = instr_word[31:26];
		rd_addr_b = instr_word[11 +: IDX_W];
		if (in_op == ppcde_pkg::OP_ADDI || in_op == ppcde_pkg::OP_ADDIS) begin
			rd_addr_a = instr_word[16 +: IDX_W];
		end else begin
			rd_addr_a = instr_word[21 +: IDX_W];
		end
	end

	// Decode fields of the word in execute
	logic [5:0] op;
	logic [4:0] f1;
	logic [4:0] f2;
	logic [4:0] f3;
	logic [9:0] xo;

	assign op = instr_s1[31:26];
	assign f1 = instr_s1[25:21];
	assign f2 = instr_s1[20:16];
	assign f3 = instr_s1[15:11];
	assign xo = instr_s1[10:1];

	// Resolve operands: forward the last write, unwritten entries read zero
	logic [IDX_W-1:0]           idx_a;
	logic [IDX_W-1:0]           idx_b;
	logic [ppcde_pkg::XLEN-1:0] opa;
	logic [ppcde_pkg::XLEN-1:0] opb;

	always_comb begin
		if (op == ppcde_pkg::OP_ADDI || op == ppcde_pkg::OP_ADDIS) begin
			idx_a = f2[IDX_W-1:0];
		end else begin
			idx_a = f1[IDX_W-1:0];
		end
		idx_b = f3[IDX_W-1:0];
		if (fwd_en_q && fwd_idx_q == idx_a) begin
			opa = fwd_val_q;
		end else if (gpr_valid_q[idx_a]) begin
			opa = rda_s1;
		end else begin
			opa = '0;
		end
		if (fwd_en_q && fwd_idx_q == idx_b) begin
			opb = fwd_val_q;
		end else if (gpr_valid_q[idx_b]) begin
			opb = rdb_s1;
		end else begin
			opb = '0;
		end
	end

	// Execute one instruction
	ppcde_pkg::status_t              ex_status;
	logic [ppcde_pkg::XLEN-1:0]      ex_next;
	logic                            ex_wr;
	logic [ppcde_pkg::RIDX_W-1:0]    ex_widx;
	logic [ppcde_pkg::XLEN-1:0]      ex_wval;
	logic [ppcde_pkg::LEVEL_W-1:0]   ex_level;
	logic [ppcde_pkg::CRLEN-1:0]     ex_cr;
	logic [ppcde_pkg::XLEN-1:0]      ex_lr;
	logic [ppcde_pkg::XLEN-1:0]      ex_msr;
	logic [ppcde_pkg::XLEN-1:0]      pc_plus4;
	logic [ppcde_pkg::XLEN-1:0]      imm_add;
	logic [ppcde_pkg::XLEN-1:0]      imm_log;
	logic [ppcde_pkg::XLEN-1:0]      br_off;

	always_comb begin
		pc_plus4 = pc_q + 64'd4;
		if (op == ppcde_pkg::OP_ADDIS) begin
			imm_add = {{32{instr_s1[15]}}, instr_s1[15:0], 16'h0000};
		end else begin
			imm_add = {{48{instr_s1[15]}}, instr_s1[15:0]};
		end
		if (op == ppcde_pkg::OP_ORIS || op == ppcde_pkg::OP_XORIS) begin
			imm_log = {32'h0, instr_s1[15:0], 16'h0000};
		end else begin
			imm_log = {48'h0, instr_s1[15:0]};
		end
		br_off = {{38{instr_s1[25]}}, instr_s1[25:2], 2'b00};

		ex_status = ppcde_pkg::ST_OK;
		ex_next   = pc_plus4;
		ex_wr     = 1'b0;
		ex_widx   = '0;
		ex_wval   = '0;
		ex_level  = '0;
		ex_cr     = cr_q;
		ex_lr     = lr_q;
		ex_msr    = msr_q;

		unique case (op)
			ppcde_pkg::OP_ADDI, ppcde_pkg::OP_ADDIS: begin
				ex_wr   = 1'b1;
				ex_widx = f1;
				ex_wval = ((f2 == 5'd0) ? 64'd0 : opa) + imm_add;
			end
			ppcde_pkg::OP_ORI, ppcde_pkg::OP_ORIS: begin
				ex_wr   = 1'b1;
				ex_widx = f2;
				ex_wval = opa | imm_log;
			end
			ppcde_pkg::OP_XORI, ppcde_pkg::OP_XORIS: begin
				ex_wr   = 1'b1;
				ex_widx = f2;
				ex_wval = opa ^ imm_log;
			end
			ppcde_pkg::OP_SC: begin
				ex_status = ppcde_pkg::ST_SYSCALL;
				ex_level  = instr_s1[11:5];
			end
			ppcde_pkg::OP_B: begin
				if (instr_s1[1]) begin
					ex_status = ppcde_pkg::ST_UNSUP;
				end else begin
					if (instr_s1[0]) begin
						ex_lr = pc_plus4;
					end
					ex_next = pc_q + br_off;
				end
			end
			ppcde_pkg::OP_GRP19: begin
				unique case (xo)
					ppcde_pkg::XO19_ISYNC: begin
						ex_cr = cr_q;
					end
					ppcde_pkg::XO19_CRXOR: begin
						// bit n of CR counts from the most significant end
						ex_cr[~f1] = cr_q[~f2] ^ cr_q[~f3];
					end
					default: begin
						ex_status = ppcde_pkg::ST_UNSUP;
					end
				endcase
			end
			ppcde_pkg::OP_GRP31: begin
				unique case (xo)
					ppcde_pkg::XO31_MFSPR: begin
						if (f3 == 5'd0 && f2 == ppcde_pkg::SPR_LR_LO) begin
							ex_wr   = 1'b1;
							ex_widx = f1;
							ex_wval = lr_q;
						end else begin
							ex_status = ppcde_pkg::ST_UNSUP;
						end
					end
					ppcde_pkg::XO31_MFMSR: begin
						ex_wr   = 1'b1;
						ex_widx = f1;
						ex_wval = msr_q;
					end
					ppcde_pkg::XO31_MTMSR: begin
						if (instr_s1[16]) begin
							ex_status = ppcde_pkg::ST_UNSUP;
						end else begin
							ex_msr = opa;
						end
					end
					ppcde_pkg::XO31_OR: begin
						if (instr_s1[0]) begin
							ex_status = ppcde_pkg::ST_UNSUP;
						end else begin
							ex_wr   = 1'b1;
							ex_widx = f2;
							ex_wval = opa | opb;
						end
					end
					default: begin
						ex_status = ppcde_pkg::ST_UNSUP;
					end
				endcase
			end
			default: begin
				ex_status = ppcde_pkg::ST_UNSUP;
			end
		endcase

		// Unsupported word: drop every state change, hold the PC
		if (ex_status == ppcde_pkg::ST_UNSUP) begin
			ex_next = pc_q;
			ex_wr   = 1'b0;
			ex_widx = '0;
			ex_wval = '0;
			ex_cr   = cr_q;
			ex_lr   = lr_q;
			ex_msr  = msr_q;
		end
	end

	// Register file: read at accept, write back at execute
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rda_s1 <= gpr_mem[rd_addr_a];
			rdb_s1 <= gpr_mem[rd_addr_b];
		end
		if (ex_fire && ex_wr) begin
			gpr_mem[ex_widx[IDX_W-1:0]] <= ex_wval;
		end
	end

	// Hold the accepted word for execute
	always_ff @(posedge clk) begin
		if (in_fire) begin
			instr_s1 <= instr_word;
		end
	end

	// Advance control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= '0;
			lr_q        <= '0;
			cr_q        <= '0;
			msr_q       <= '0;
			gpr_valid_q <= '0;
			fwd_en_q    <= 1'b0;
			fwd_idx_q   <= '0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (ex_fire) begin
				valid_s1 <= 1'b0;
			end
			if (ex_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ex_fire) begin
				pc_q  <= ex_next;
				lr_q  <= ex_lr;
				cr_q  <= ex_cr;
				msr_q <= ex_msr;
				if (ex_wr) begin
					gpr_valid_q[ex_widx[IDX_W-1:0]] <= 1'b1;
					fwd_en_q  <= 1'b1;
					fwd_idx_q <= ex_widx[IDX_W-1:0];
				end
			end
		end
	end

	// Capture the result item and the forwarded value
	always_ff @(posedge clk) begin
		if (ex_fire) begin
			status_q     <= ex_status;
			next_pc_q    <= ex_next;
			dest_valid_q <= ex_wr;
			dest_index_q <= ex_widx;
			dest_value_q <= ex_wval;
			level_q      <= ex_level;
			cr_out_q     <= ex_cr;
			lr_out_q     <= ex_lr;
			if (ex_wr) begin
				fwd_val_q <= ex_wval;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign next_pc       = next_pc_q;
	assign dest_valid    = dest_valid_q;
	assign dest_index    = dest_index_q;
	assign dest_value    = dest_value_q;
	assign syscall_level = level_q;
	assign cr_value      = cr_out_q;
	assign lr_value      = lr_out_q;

endmodule

>>> rtl/ppcde_checker.sv
// Port-level checker for the PowerPC subset execute block, with its bind
`include "ppc_subset_decode_execute_top_assert.svh"

module ppcde_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [1:0]                         status,
	input logic [ppcde_pkg::XLEN-1:0]         next_pc,
	input logic                               dest_valid,
	input logic [ppcde_pkg::RIDX_W-1:0]       dest_index,
	input logic [ppcde_pkg::XLEN-1:0]         dest_value,
	input logic [ppcde_pkg::LEVEL_W-1:0]      syscall_level
);

	// A stalled result holds
	`PPCDE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(next_pc) && $stable(dest_value))

	// An unsupported word writes no register
	`PPCDE_ASSERT_NOW(a_unsup_no_write, clk, arst_n, out_valid && status == ppcde_pkg::ST_UNSUP, !dest_valid)

	// No write reports index and value zero
	`PPCDE_ASSERT_NOW(a_no_write_zero, clk, arst_n, out_valid && !dest_valid, dest_index == 5'd0 && dest_value == 64'd0)

	// Only a system call carries a level
	`PPCDE_ASSERT_NOW(a_level_only_sc, clk, arst_n, out_valid && status != ppcde_pkg::ST_SYSCALL, syscall_level == 7'd0)

endmodule

bind ppc_subset_decode_execute_top ppcde_checker u_ppcde_checker (.*);
